@@ rtl/core/dts_pkg.sv @@
// types, codes and helper functions shared by the datalog token scanner
package dts_pkg;

    localparam int LINE_WIDTH   = 16;
    localparam int OFFSET_WIDTH = 24;
    localparam int LENGTH_WIDTH = 16;
    localparam int KIND_WIDTH   = 5;
    localparam int NUM_KW       = 4;
    localparam int KW_MAX_LEN   = 7;

    // token kinds
    localparam logic [KIND_WIDTH-1:0] K_COMMA     = 5'd0;
    localparam logic [KIND_WIDTH-1:0] K_PERIOD    = 5'd1;
    localparam logic [KIND_WIDTH-1:0] K_QMARK     = 5'd2;
    localparam logic [KIND_WIDTH-1:0] K_LPAREN    = 5'd3;
    localparam logic [KIND_WIDTH-1:0] K_RPAREN    = 5'd4;
    localparam logic [KIND_WIDTH-1:0] K_COLON     = 5'd5;
    localparam logic [KIND_WIDTH-1:0] K_COLONDASH = 5'd6;
    localparam logic [KIND_WIDTH-1:0] K_MULTIPLY  = 5'd7;
    localparam logic [KIND_WIDTH-1:0] K_ADD       = 5'd8;
    localparam logic [KIND_WIDTH-1:0] K_KEYWORD0  = 5'd9;
    localparam logic [KIND_WIDTH-1:0] K_ID        = 5'd13;
    localparam logic [KIND_WIDTH-1:0] K_STRING    = 5'd14;
    localparam logic [KIND_WIDTH-1:0] K_UNDEFINED = 5'd15;
    localparam logic [KIND_WIDTH-1:0] K_EOF       = 5'd16;

    // character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_DASH   = 8'h2D;

    // keyword text, padded with zero bytes past each keyword's length
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
        '{"S", "c", "h", "e", "m", "e", "s"},
        '{"R", "u", "l", "e", "s", 8'h00, 8'h00},
        '{"F", "a", "c", "t", "s", 8'h00, 8'h00},
        '{"Q", "u", "e", "r", "i", "e", "s"}
    };
    localparam logic [LENGTH_WIDTH-1:0] KW_LEN [NUM_KW] = '{
        LENGTH_WIDTH'(7), LENGTH_WIDTH'(5), LENGTH_WIDTH'(5), LENGTH_WIDTH'(7)
    };

    // scanner modes
    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_COLON,
        M_HASH,
        M_LINECOM,
        M_BLOCK,
        M_BLOCKBAR,
        M_STRING,
        M_STRQUOTE
    } t_mode;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]   token_kind;
        logic [LINE_WIDTH-1:0]   token_line;
        logic [OFFSET_WIDTH-1:0] token_start;
        logic [LENGTH_WIDTH-1:0] token_length;
        logic                    last_of_run;
    } t_out_item;

    // saturating increments
    function automatic logic [LINE_WIDTH-1:0] sat_line(input logic [LINE_WIDTH-1:0] v);
        return (&v) ? v : v + LINE_WIDTH'(1);
    endfunction

    function automatic logic [OFFSET_WIDTH-1:0] sat_off(input logic [OFFSET_WIDTH-1:0] v);
        return (&v) ? v : v + OFFSET_WIDTH'(1);
    endfunction

    function automatic logic [LENGTH_WIDTH-1:0] sat_len(input logic [LENGTH_WIDTH-1:0] v);
        return (&v) ? v : v + LENGTH_WIDTH'(1);
    endfunction

    // keyword k still matches when character c sits at position pos
    function automatic logic kw_hit(input int k, input logic [LENGTH_WIDTH-1:0] pos,
                                    input logic [7:0] c);
        logic [2:0] idx;
        idx = pos[2:0];
        if (pos >= KW_LEN[k] || idx >= 3'(KW_MAX_LEN)) begin
            return 1'b0;
        end
        return KW_TEXT[k][idx] == c;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

endpackage

@@ rtl/core/datalog_token_scanner.sv @@
// datalog token scanner: byte-serial lexer with a four-entry token queue
// throughput: one byte per cycle while input ready is high; a byte that ends
//   a token and emits another puts two tokens in the queue, which drains one
//   token per cycle while output ready is high
// input ready drops while the token queue has fewer than two free entries
// synchronous active-low reset: idle mode, line = 1, offset 0, empty queue
module datalog_token_scanner
    import dts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [LINE_WIDTH-1:0] i_cfg_data
);

    // scanner state
    t_mode                   r_mode, n_mode;
    logic [LINE_WIDTH-1:0]   r_first_line;
    logic [LINE_WIDTH-1:0]   r_line, n_line;
    logic [OFFSET_WIDTH-1:0] r_off, n_off;
    logic [LINE_WIDTH-1:0]   r_pline, n_pline;
    logic [OFFSET_WIDTH-1:0] r_poff, n_poff;
    logic [LENGTH_WIDTH-1:0] r_plen, n_plen;
    logic [NUM_KW-1:0]       r_mask, n_mask;

    // token queue
    t_out_item               r_q [4];
    logic [1:0]              r_wp, r_rp;
    logic [2:0]              r_cnt;

    logic                    accept, pop;
    logic [7:0]              c;

    // fresh scan of the current byte
    t_mode                   f_mode;
    logic                    f_emit, f_begin, f_nl;
    logic [KIND_WIDTH-1:0]   f_kind;
    logic [NUM_KW-1:0]       hit_first, hit_now;

    // emitted tokens: pending flush first, then fresh or eof
    logic                    pv, qv;
    t_out_item               pre_tok, post_tok, tok_a, tok_b;
    logic                    do_fresh;
    logic [KIND_WIDTH-1:0]   id_kind;
    logic [1:0]              npush;

    assign c           = i_in_data.char_code;
    assign accept      = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;
    assign o_in_ready  = i_rst_n && (r_cnt <= 3'd2);
    // a first-line write waits while an input item is offered
    assign o_cfg_ready = i_rst_n && !i_in_valid;
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_q[r_rp];

    // keyword match bits at the first position and at the pending length
    always_comb begin
        for (int k = 0; k < NUM_KW; k++) begin
            hit_first[k] = kw_hit(k, '0, c);
            hit_now[k]   = kw_hit(k, r_plen, c);
        end
    end

    // identifier kind: first keyword still matching with equal length
    always_comb begin
        id_kind = K_ID;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (r_mask[k] && r_plen == KW_LEN[k]) begin
                id_kind = K_KEYWORD0 + KIND_WIDTH'(k);
            end
        end
    end

    // classify a byte scanned afresh
    always_comb begin
        f_mode  = M_IDLE;
        f_emit  = 1'b0;
        f_begin = 1'b0;
        f_nl    = 1'b0;
        f_kind  = K_UNDEFINED;
        case (c)
            CH_NL:     f_nl = 1'b1;
            CH_COMMA:  begin f_emit = 1'b1; f_kind = K_COMMA;    end
            CH_PERIOD: begin f_emit = 1'b1; f_kind = K_PERIOD;   end
            CH_QMARK:  begin f_emit = 1'b1; f_kind = K_QMARK;    end
            CH_LPAREN: begin f_emit = 1'b1; f_kind = K_LPAREN;   end
            CH_RPAREN: begin f_emit = 1'b1; f_kind = K_RPAREN;   end
            CH_STAR:   begin f_emit = 1'b1; f_kind = K_MULTIPLY; end
            CH_PLUS:   begin f_emit = 1'b1; f_kind = K_ADD;      end
            CH_COLON:  begin f_begin = 1'b1; f_mode = M_COLON;   end
            CH_HASH:   begin f_begin = 1'b1; f_mode = M_HASH;    end
            CH_QUOTE:  begin f_begin = 1'b1; f_mode = M_STRING;  end
            default: begin
                if (is_alpha(c)) begin
                    f_begin = 1'b1;
                    f_mode  = M_IDENT;
                end else if (!is_space(c)) begin
                    f_emit = 1'b1;
                end
            end
        endcase
    end

    // next state and emitted tokens for the current item
    always_comb begin
        n_mode   = r_mode;
        n_line   = r_line;
        n_off    = r_off;
        n_pline  = r_pline;
        n_poff   = r_poff;
        n_plen   = r_plen;
        n_mask   = r_mask;
        pv       = 1'b0;
        qv       = 1'b0;
        do_fresh = 1'b0;
        pre_tok  = '{token_kind: K_UNDEFINED, token_line: r_pline, token_start: r_poff,
                     token_length: r_plen, last_of_run: 1'b1};
        post_tok = '{token_kind: f_kind, token_line: r_line, token_start: r_off,
                     token_length: LENGTH_WIDTH'(1), last_of_run: 1'b1};

        if (i_in_data.end_of_input) begin
            // flush pending token, then eof, then start a fresh text
            case (r_mode)
                M_IDENT: begin
                    pv = 1'b1;
                    pre_tok.token_kind = id_kind;
                end
                M_COLON: begin
                    pv = 1'b1;
                    pre_tok.token_kind   = K_COLON;
                    pre_tok.token_length = LENGTH_WIDTH'(1);
                end
                M_STRING, M_BLOCK, M_BLOCKBAR: pv = 1'b1;
                M_STRQUOTE: begin
                    pv = 1'b1;
                    pre_tok.token_kind = K_STRING;
                end
                default: ;
            endcase
            qv = 1'b1;
            post_tok.token_kind   = K_EOF;
            post_tok.token_length = '0;
            n_mode  = M_IDLE;
            n_line  = r_first_line;
            n_off   = '0;
            n_pline = '0;
            n_poff  = '0;
            n_plen  = '0;
            n_mask  = '1;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        n_mask = r_mask & hit_now;
                        n_plen = sat_len(r_plen);
                    end else begin
                        pv = 1'b1;
                        pre_tok.token_kind = id_kind;
                        do_fresh = 1'b1;
                    end
                end
                M_COLON: begin
                    pv = 1'b1;
                    if (c == CH_DASH) begin
                        pre_tok.token_kind   = K_COLONDASH;
                        pre_tok.token_length = LENGTH_WIDTH'(2);
                        n_mode = M_IDLE;
                    end else begin
                        pre_tok.token_kind   = K_COLON;
                        pre_tok.token_length = LENGTH_WIDTH'(1);
                        do_fresh = 1'b1;
                    end
                end
                M_HASH: begin
                    if (c == CH_BAR) begin
                        n_plen = sat_len(r_plen);
                        n_mode = M_BLOCK;
                    end else if (c == CH_NL) begin
                        n_line = sat_line(r_line);
                        n_mode = M_IDLE;
                    end else begin
                        n_mode = M_LINECOM;
                    end
                end
                M_LINECOM: begin
                    if (c == CH_NL) begin
                        n_line = sat_line(r_line);
                        n_mode = M_IDLE;
                    end
                end
                M_BLOCK, M_BLOCKBAR: begin
                    n_plen = sat_len(r_plen);
                    if (c == CH_HASH && r_mode == M_BLOCKBAR) begin
                        n_mode = M_IDLE;
                    end else if (c == CH_BAR) begin
                        n_mode = M_BLOCKBAR;
                    end else begin
                        if (c == CH_NL) n_line = sat_line(r_line);
                        n_mode = M_BLOCK;
                    end
                end
                M_STRING: begin
                    n_plen = sat_len(r_plen);
                    if (c == CH_NL) begin
                        n_line = sat_line(r_line);
                    end else if (c == CH_QUOTE) begin
                        n_mode = M_STRQUOTE;
                    end
                end
                M_STRQUOTE: begin
                    if (c == CH_QUOTE) begin
                        n_plen = sat_len(r_plen);
                        n_mode = M_STRING;
                    end else begin
                        pv = 1'b1;
                        pre_tok.token_kind = K_STRING;
                        do_fresh = 1'b1;
                    end
                end
                default: do_fresh = 1'b1;
            endcase

            // byte scanned afresh, from idle or after a pending token ended
            if (do_fresh) begin
                n_mode = f_mode;
                qv     = f_emit;
                if (f_nl) n_line = sat_line(r_line);
                if (f_begin) begin
                    n_pline = r_line;
                    n_poff  = r_off;
                    n_plen  = LENGTH_WIDTH'(1);
                    if (f_mode == M_IDENT) n_mask = hit_first;
                end
            end
            n_off = sat_off(r_off);
        end
    end

    // order the tokens for the queue
    always_comb begin
        tok_a = pv ? pre_tok : post_tok;
        tok_a.last_of_run = !(pv && qv);
        tok_b = post_tok;
        npush = {1'b0, pv} + {1'b0, qv};
    end

    // scanner state and first-line register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_IDLE;
            r_first_line <= LINE_WIDTH'(1);
            r_line       <= LINE_WIDTH'(1);
            r_off        <= '0;
            r_pline      <= '0;
            r_poff       <= '0;
            r_plen       <= '0;
            r_mask       <= '1;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_off   <= n_off;
            r_pline <= n_pline;
            r_poff  <= n_poff;
            r_plen  <= n_plen;
            r_mask  <= n_mask;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_first_line <= i_cfg_data;
            r_line       <= i_cfg_data;
        end
    end

    // token queue storage
    always_ff @(posedge i_clk) begin
        if (accept && npush != 2'd0) begin
            r_q[r_wp] <= tok_a;
            if (npush == 2'd2) r_q[r_wp + 2'd1] <= tok_b;
        end
    end

    // token queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) r_wp <= r_wp + npush;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + (accept ? {1'b0, npush} : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

endmodule
